// ===== hw/rtl/phd_pkg.sv =====
// Shared types, constants and the arctangent table function for the heading and distance block.
package phd_pkg;

  // Fixed-point formats of the heading path
  localparam int NORM_W        = 60;
  localparam int NORM_STEPS    = 6;
  localparam int CORDIC_ITERS  = 62;
  localparam int KBITS         = 17;
  localparam int PROD_W        = 80;
  localparam int ZC_W          = 61;
  localparam int HEAD_W        = 20;
  localparam int DIST_W        = 25;

  localparam logic [63:0] PI60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI60_HALF = PI60 >> 1;

  localparam logic [17:0] SCALE     = 18'd180000;
  localparam logic [KBITS-1:0] K_MAX  = 17'd89999;
  localparam logic [KBITS-1:0] ANG_45 = 17'd45000;
  localparam logic signed [HEAD_W-1:0] H_90  = 20'sd90000;
  localparam logic signed [HEAD_W-1:0] H_180 = 20'sd180000;
  localparam logic signed [HEAD_W-1:0] H_270 = 20'sd270000;

  // One word of the rotation chain
  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } phd_cord_t;

  // Case flags that travel alongside the angle
  typedef struct packed {
    logic dx_zero;
    logic dx_pos;
    logic dy_pos;
    logic dy_zero;
    logic diag;
    logic neg;
  } phd_flags_t;

  // atan(2^-i) with 60 fraction bits, from the truncated alternating series
  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    int k;
    pos = '0;
    neg = '0;
    if (i == 0) begin
      return PI60 >> 2;
    end
    for (k = 0; k < 31; k++) begin
      if (i * (2 * k + 1) <= 60) begin
        term = (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
        if ((k % 2) == 1) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
    end
    return pos - neg;
  endfunction

endpackage

// ===== hw/rtl/phd_norm_cell.sv =====
// One normalising cell: shifts both magnitudes left by a fixed amount if the larger stays in range.
module phd_norm_cell #(
  parameter int SH = 1
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [phd_pkg::NORM_W-1:0]   nx_in,
  input  logic [phd_pkg::NORM_W-1:0]   ny_in,
  input  logic [phd_pkg::NORM_W-1:0]   nm_in,
  output logic [phd_pkg::NORM_W-1:0]   nx,
  output logic [phd_pkg::NORM_W-1:0]   ny,
  output logic [phd_pkg::NORM_W-1:0]   nm
);
  import phd_pkg::*;

  logic fits;

  // Shift only while the larger magnitude stays below 2^60
  assign fits = ((nm_in >> (NORM_W - SH)) == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      nx <= fits ? (nx_in << SH) : nx_in;
      ny <= fits ? (ny_in << SH) : ny_in;
      nm <= fits ? (nm_in << SH) : nm_in;
    end
  end

endmodule

// ===== hw/rtl/phd_cordic_cell.sv =====
// One vectoring rotation cell of the arctangent chain.
module phd_cordic_cell #(
  parameter int ITER = 0
) (
  input  logic                clk,
  input  logic                en,
  input  phd_pkg::phd_cord_t  cin,
  output phd_pkg::phd_cord_t  cout
);
  import phd_pkg::*;

  localparam logic signed [63:0] TAB = $signed(atan_entry(ITER));

  logic signed [63:0] xs;
  logic signed [63:0] ys;
  phd_cord_t          cout_next;

  // Rotate towards the x axis and accumulate the angle
  always_comb begin
    xs        = cin.x >>> ITER;
    ys        = cin.y >>> ITER;
    cout_next = cin;
    if (cin.y > 64'sd0) begin
      cout_next.x = cin.x + ys;
      cout_next.y = cin.y - xs;
      cout_next.z = cin.z + TAB;
    end else begin
      cout_next.x = cin.x - ys;
      cout_next.y = cin.y + xs;
      cout_next.z = cin.z - TAB;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cout <= cout_next;
    end
  end

endmodule

// ===== hw/rtl/phd_conv_cell.sv =====
// One bit of the radians to millidegrees conversion: tries one quotient bit against pi.
module phd_conv_cell #(
  parameter int BIT = 0
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [phd_pkg::PROD_W-1:0]   rem_in,
  input  logic [phd_pkg::KBITS-1:0]    k_in,
  output logic [phd_pkg::PROD_W-1:0]   rem,
  output logic [phd_pkg::KBITS-1:0]    k
);
  import phd_pkg::*;

  localparam logic [PROD_W-1:0] STEP = PROD_W'(PI60) << BIT;

  logic take;

  assign take = (rem_in >= STEP);

  // Keep the bit if its multiple of pi still fits in the remainder
  always_ff @(posedge clk) begin
    if (en) begin
      rem <= take ? (rem_in - STEP) : rem_in;
      k   <= take ? (k_in | (KBITS'(1) << BIT)) : k_in;
    end
  end

endmodule

// ===== hw/rtl/phd_sqrt_cell.sv =====
// One bit of the restoring integer square root.
module phd_sqrt_cell #(
  parameter int SW  = 50,
  parameter int RW  = 25,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [SW-1:0] rem_in,
  input  logic [RW-1:0] q_in,
  output logic [SW-1:0] rem,
  output logic [RW-1:0] q
);
  localparam int TW = SW + 1;

  logic [TW-1:0] trial;
  logic          take;

  // (q + 2^b)^2 - q^2 = q * 2^(b+1) + 2^(2b)
  assign trial = (TW'(q_in) << (BIT + 1)) + (TW'(1) << (2 * BIT));
  assign take  = (trial <= TW'(rem_in));

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= take ? (rem_in - SW'(trial)) : rem_in;
      q   <= take ? (q_in | (RW'(1) << BIT)) : q_in;
    end
  end

endmodule

// ===== hw/rtl/point_heading_and_distance_top.sv =====
// Throughput: one word per cycle; the whole pipeline holds while a result waits under stall.
// Depth: 1 input, 6 normalise, 62 rotation, 3 scale, 17 conversion cells and 1 output stage;
// the square root runs alongside in COORD_BITS+1 cells and is delayed to match.
// Reset clears every valid bit at once; payload registers are not reset.
module point_heading_and_distance_top #(
  parameter int COORD_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic signed [COORD_BITS-1:0]        from_x,
  input  logic signed [COORD_BITS-1:0]        from_y,
  input  logic signed [COORD_BITS-1:0]        to_x,
  input  logic signed [COORD_BITS-1:0]        to_y,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic signed [phd_pkg::HEAD_W-1:0]   heading_mdeg,
  output logic [phd_pkg::DIST_W-1:0]          distance
);
  import phd_pkg::*;

  localparam int CW     = COORD_BITS + 1;
  localparam int RW     = COORD_BITS + 1;
  localparam int SW     = 2 * RW;
  localparam int ALEN   = NORM_STEPS + CORDIC_ITERS + 3 + KBITS;
  localparam int RDLY   = ALEN - 3 - RW;
  localparam int DEPTH  = ALEN + 2;

  logic             en;
  logic [DEPTH-1:0] vld;

  // Advance everything unless a finished word is held at the output
  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;
  assign rsp_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], req_valid};
    end
  end

  // Input stage: differences, magnitudes and case flags
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic [CW-1:0]        adx_c;
  logic [CW-1:0]        ady_c;
  phd_flags_t           flags_c;
  logic [CW-1:0]        adx;
  logic [CW-1:0]        ady;
  phd_flags_t           flags;

  always_comb begin
    dx              = {to_x[COORD_BITS-1], to_x} - {from_x[COORD_BITS-1], from_x};
    dy              = {to_y[COORD_BITS-1], to_y} - {from_y[COORD_BITS-1], from_y};
    adx_c           = dx[CW-1] ? (-dx) : dx;
    ady_c           = dy[CW-1] ? (-dy) : dy;
    flags_c.dx_zero = (dx == '0);
    flags_c.dy_zero = (dy == '0);
    flags_c.dx_pos  = !dx[CW-1] && (dx != '0);
    flags_c.dy_pos  = !dy[CW-1] && (dy != '0);
    flags_c.diag    = (adx_c == ady_c);
    flags_c.neg     = (dx[CW-1] != dy[CW-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adx   <= adx_c;
      ady   <= ady_c;
      flags <= flags_c;
    end
  end

  // Normalising cells
  logic [NORM_W-1:0] nx [NORM_STEPS+1];
  logic [NORM_W-1:0] ny [NORM_STEPS+1];
  logic [NORM_W-1:0] nm [NORM_STEPS+1];

  assign nx[0] = NORM_W'(adx);
  assign ny[0] = NORM_W'(ady);
  assign nm[0] = (adx > ady) ? NORM_W'(adx) : NORM_W'(ady);

  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    phd_norm_cell #(
      .SH(1 << (NORM_STEPS - 1 - j))
    ) u_norm (
      .clk  (clk),
      .en   (en),
      .nx_in(nx[j]),
      .ny_in(ny[j]),
      .nm_in(nm[j]),
      .nx   (nx[j+1]),
      .ny   (ny[j+1]),
      .nm   (nm[j+1])
    );
  end

  // Rotation chain
  phd_cord_t cord [CORDIC_ITERS+1];

  always_comb begin
    cord[0].x = $signed(64'(nx[NORM_STEPS]));
    cord[0].y = $signed(64'(ny[NORM_STEPS]));
    cord[0].z = '0;
  end

  for (genvar j = 0; j < CORDIC_ITERS; j++) begin : g_cordic
    phd_cordic_cell #(
      .ITER(j)
    ) u_cordic (
      .clk (clk),
      .en  (en),
      .cin (cord[j]),
      .cout(cord[j+1])
    );
  end

  // Clamp the angle and scale by 180000 in two partial products
  logic signed [63:0] zf;
  logic [ZC_W-1:0]    zc;
  logic [49:0]        plo;
  logic [ZC_W-33:0]   zh;
  logic [49:0]        plo_q;
  logic [46:0]        phi;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    zf = cord[CORDIC_ITERS].z;
    if (zf[63]) begin
      zc = '0;
    end else if (zf > $signed(PI60_HALF)) begin
      zc = ZC_W'(PI60_HALF);
    end else begin
      zc = zf[ZC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plo   <= 50'(zc[31:0]) * 50'(SCALE);
      zh    <= zc[ZC_W-1:32];
      phi   <= 47'(zh) * 47'(SCALE);
      plo_q <= plo;
      prod  <= (PROD_W'(phi) << 32) + PROD_W'(plo_q);
    end
  end

  // Conversion cells, one quotient bit each
  logic [PROD_W-1:0] crem [KBITS+1];
  logic [KBITS-1:0]  ck   [KBITS+1];

  assign crem[0] = prod;
  assign ck[0]   = '0;

  for (genvar j = 0; j < KBITS; j++) begin : g_conv
    phd_conv_cell #(
      .BIT(KBITS - 1 - j)
    ) u_conv (
      .clk   (clk),
      .en    (en),
      .rem_in(crem[j]),
      .k_in  (ck[j]),
      .rem   (crem[j+1]),
      .k     (ck[j+1])
    );
  end

  // Sum of squares
  logic [SW-1:0] ax_w;
  logic [SW-1:0] ay_w;
  logic [SW-1:0] sqx;
  logic [SW-1:0] sqx_q;
  logic [SW-1:0] sqy;
  logic [CW-1:0] ady_q;
  logic [SW-1:0] sumsq;

  assign ax_w = SW'(adx);
  assign ay_w = SW'(ady_q);

  always_ff @(posedge clk) begin
    if (en) begin
      sqx   <= ax_w * ax_w;
      ady_q <= ady;
      sqy   <= ay_w * ay_w;
      sqx_q <= sqx;
      sumsq <= sqx_q + sqy;
    end
  end

  // Square root cells
  logic [SW-1:0] srem [RW+1];
  logic [RW-1:0] sq   [RW+1];

  assign srem[0] = sumsq;
  assign sq[0]   = '0;

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    phd_sqrt_cell #(
      .SW (SW),
      .RW (RW),
      .BIT(RW - 1 - j)
    ) u_sqrt (
      .clk   (clk),
      .en    (en),
      .rem_in(srem[j]),
      .q_in  (sq[j]),
      .rem   (srem[j+1]),
      .q     (sq[j+1])
    );
  end

  // Delay lines for the root and the flags
  logic [RW-1:0] root_line [RDLY];
  phd_flags_t    flag_line [ALEN];

  always_ff @(posedge clk) begin
    if (en) begin
      root_line[0] <= sq[RW];
      for (int j = 1; j < RDLY; j++) begin
        root_line[j] <= root_line[j-1];
      end
      flag_line[0] <= flags;
      for (int j = 1; j < ALEN; j++) begin
        flag_line[j] <= flag_line[j-1];
      end
    end
  end

  // Compose the heading
  phd_flags_t                 fl;
  logic [KBITS-1:0]           kc;
  logic [KBITS-1:0]           amag;
  logic signed [HEAD_W-1:0]   asig;
  logic signed [HEAD_W-1:0]   heading_next;
  logic [RW+DIST_W-1:0]       root_w;

  always_comb begin
    fl   = flag_line[ALEN-1];
    kc   = (ck[KBITS] > K_MAX) ? K_MAX : ck[KBITS];
    if (fl.dy_zero) begin
      amag = '0;
    end else if (fl.diag) begin
      amag = ANG_45;
    end else begin
      amag = kc;
    end
    asig = fl.neg ? -$signed(HEAD_W'(amag)) : $signed(HEAD_W'(amag));
    if (fl.dx_zero) begin
      heading_next = fl.dy_pos ? H_270 : H_90;
    end else if (fl.dx_pos) begin
      heading_next = -asig;
    end else begin
      heading_next = H_180 - asig;
    end
    root_w = (RW + DIST_W)'(root_line[RDLY-1]);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      heading_mdeg <= heading_next;
      distance     <= root_w[DIST_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/phd_check.sv =====
// Port-level checks for the heading and distance block, bound to its top level.
module phd_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_stall,
  input logic                              rsp_valid,
  input logic                              rsp_stall,
  input logic signed [phd_pkg::HEAD_W-1:0] heading_mdeg,
  input logic [phd_pkg::DIST_W-1:0]        distance
);
  import phd_pkg::*;

  // Hold a stalled result word
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(heading_mdeg) && $stable(distance))
    else $error("stalled result word changed");

  // Heading stays within its range
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (heading_mdeg >= -20'sd89999) && (heading_mdeg <= H_270))
    else $error("heading out of range");

  // Coincident points give the downward special heading
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (distance == '0) |-> heading_mdeg == H_90)
    else $error("zero distance with wrong heading");

  // Input is held off exactly while a result waits
  assert property (@(posedge clk) disable iff (rst)
    req_stall == (rsp_valid && rsp_stall))
    else $error("input stall does not follow output hold");

  // Reset empties the pipeline
  assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("result word valid after reset");

endmodule

bind point_heading_and_distance_top phd_check u_check (.*);
